// ----- hdl/rrcs_pkg.sv -----
// rrcs_pkg: shared types and codes for the raid request command sequencer
// used by rrcs_ctrl, rrcs_dp, the top level and its checker; no dependencies
`default_nettype none

package rrcs_pkg;

   localparam int CmdW     = 3;
   localparam int DiskW    = 4;
   localparam int BlkW     = 12;
   localparam int StatW    = 2;
   localparam int LbW      = 16;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 8;
   localparam int LevelW   = 3;

   // disk commands
   localparam logic [CmdW-1:0] CMD_NONE  = 3'd0;
   localparam logic [CmdW-1:0] CMD_READ  = 3'd1;
   localparam logic [CmdW-1:0] CMD_WRITE = 3'd2;
   localparam logic [CmdW-1:0] CMD_RDXOR = 3'd3;
   localparam logic [CmdW-1:0] CMD_HXOR  = 3'd4;
   localparam logic [CmdW-1:0] CMD_WACC  = 3'd5;
   localparam logic [CmdW-1:0] CMD_RET   = 3'd6;

   // request status
   localparam logic [StatW-1:0] STAT_OK        = 2'd0;
   localparam logic [StatW-1:0] STAT_NO_ARRAY  = 2'd1;
   localparam logic [StatW-1:0] STAT_DISK_DOWN = 2'd2;
   localparam logic [StatW-1:0] STAT_RANGE     = 2'd3;

   // raid levels
   localparam logic [LevelW-1:0] LVL_RAID0  = 3'd0;
   localparam logic [LevelW-1:0] LVL_RAID1  = 3'd1;
   localparam logic [LevelW-1:0] LVL_RAID01 = 3'd2;
   localparam logic [LevelW-1:0] LVL_RAID4  = 3'd3;
   localparam logic [LevelW-1:0] LVL_RAID5  = 3'd4;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] REG_ARRAY_PRESENT = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_RAID_LEVEL    = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_DISK_OK_MASK  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL1,
      S_FIX1,
      S_MUL2,
      S_FIX2,
      S_PLAN,
      S_ERR,
      S_SCAN,
      S_RET,
      S_RMW_RD_DATA,
      S_RMW_WR_DATA,
      S_RMW_RD_PAR,
      S_RMW_HXOR,
      S_RMW_WACC
   } ctl_state_type;

   typedef enum logic [2:0] {
      EM_ERR,
      EM_SCAN,
      EM_RET,
      EM_RD_DATA,
      EM_WR_DATA,
      EM_RD_PAR,
      EM_HXOR,
      EM_WACC
   } emit_kind_type;

   typedef struct packed {
      logic          capture;
      logic          mul;
      logic          fix;
      logic          pass2;
      logic          plan;
      logic          idx_step;
      logic          emit_valid;
      logic          emit_last;
      emit_kind_type emit_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic plan_err;
      logic plan_rmw;
      logic ret_after;
      logic hit;
      logic more;
   } dp_stat_type;

endpackage

`default_nettype wire

// ----- hdl/rrcs_ctrl.sv -----
// rrcs_ctrl: request sequencing state machine of the raid command sequencer
// drives rrcs_dp through rrcs_pkg::ctl_cmd_type, reads rrcs_pkg::dp_stat_type
`default_nettype none

module rrcs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire rrcs_pkg::dp_stat_type stat,
   output rrcs_pkg::ctl_cmd_type     cmd
);

   rrcs_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrcs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.emit_kind  = rrcs_pkg::EM_ERR;
      busy           = (state_ff != rrcs_pkg::S_IDLE);
      case (state_ff)
         rrcs_pkg::S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = rrcs_pkg::S_MUL1;
            end
         end
         rrcs_pkg::S_MUL1: begin
            cmd.mul  = 1'b1;
            state_in = rrcs_pkg::S_FIX1;
         end
         rrcs_pkg::S_FIX1: begin
            cmd.fix  = 1'b1;
            state_in = rrcs_pkg::S_MUL2;
         end
         rrcs_pkg::S_MUL2: begin
            cmd.mul   = 1'b1;
            cmd.pass2 = 1'b1;
            state_in  = rrcs_pkg::S_FIX2;
         end
         rrcs_pkg::S_FIX2: begin
            cmd.fix   = 1'b1;
            cmd.pass2 = 1'b1;
            state_in  = rrcs_pkg::S_PLAN;
         end
         rrcs_pkg::S_PLAN: begin
            cmd.plan = 1'b1;
            if (stat.plan_err) begin
               state_in = rrcs_pkg::S_ERR;
            end else if (stat.plan_rmw) begin
               state_in = rrcs_pkg::S_RMW_RD_DATA;
            end else begin
               state_in = rrcs_pkg::S_SCAN;
            end
         end
         rrcs_pkg::S_ERR: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_last  = 1'b1;
            cmd.emit_kind  = rrcs_pkg::EM_ERR;
            state_in       = rrcs_pkg::S_IDLE;
         end
         rrcs_pkg::S_SCAN: begin
            // walk the disks upward, stop after the highest selected one
            cmd.emit_valid = stat.hit;
            cmd.emit_last  = !stat.more && !stat.ret_after;
            cmd.emit_kind  = rrcs_pkg::EM_SCAN;
            if (stat.more) begin
               cmd.idx_step = 1'b1;
            end else if (stat.ret_after) begin
               state_in = rrcs_pkg::S_RET;
            end else begin
               state_in = rrcs_pkg::S_IDLE;
            end
         end
         rrcs_pkg::S_RET: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_last  = 1'b1;
            cmd.emit_kind  = rrcs_pkg::EM_RET;
            state_in       = rrcs_pkg::S_IDLE;
         end
         rrcs_pkg::S_RMW_RD_DATA: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_kind  = rrcs_pkg::EM_RD_DATA;
            state_in       = rrcs_pkg::S_RMW_WR_DATA;
         end
         rrcs_pkg::S_RMW_WR_DATA: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_kind  = rrcs_pkg::EM_WR_DATA;
            state_in       = rrcs_pkg::S_RMW_RD_PAR;
         end
         rrcs_pkg::S_RMW_RD_PAR: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_kind  = rrcs_pkg::EM_RD_PAR;
            state_in       = rrcs_pkg::S_RMW_HXOR;
         end
         rrcs_pkg::S_RMW_HXOR: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_kind  = rrcs_pkg::EM_HXOR;
            state_in       = rrcs_pkg::S_RMW_WACC;
         end
         rrcs_pkg::S_RMW_WACC: begin
            cmd.emit_valid = 1'b1;
            cmd.emit_last  = 1'b1;
            cmd.emit_kind  = rrcs_pkg::EM_WACC;
            state_in       = rrcs_pkg::S_IDLE;
         end
         default: begin
            state_in = rrcs_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hdl/rrcs_dp.sv -----
// rrcs_dp: datapath of the raid command sequencer: config registers, block
// mapping by reciprocal multiply, command plan and result register; uses rrcs_pkg
`default_nettype none

module rrcs_dp #(
   parameter int NUM_DISKS   = 4,
   parameter int DISK_BLOCKS = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_op,
   input  wire logic [rrcs_pkg::LbW-1:0]           req_logical_block,
   input  wire logic                               csr_we,
   input  wire logic [rrcs_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [rrcs_pkg::CsrDataW-1:0]      csr_wdata,
   input  wire rrcs_pkg::ctl_cmd_type              cmd,
   output rrcs_pkg::dp_stat_type                   stat,
   output logic                                    rsp_valid,
   output logic [rrcs_pkg::CmdW-1:0]               rsp_command,
   output logic [rrcs_pkg::DiskW-1:0]              rsp_disk_number,
   output logic [rrcs_pkg::BlkW-1:0]               rsp_physical_block,
   output logic [rrcs_pkg::StatW-1:0]              rsp_status,
   output logic                                    rsp_last_command
);

   localparam int Half = NUM_DISKS / 2;
   localparam int IdxW = $clog2(NUM_DISKS);
   localparam int LbW  = rrcs_pkg::LbW;
   localparam int DskW = rrcs_pkg::DiskW;
   localparam int ProdW = LbW + 32;
   localparam int RemW  = LbW + DskW;

   // floor(2^31 / divisor): quotient estimate is exact or one short for 16-bit values
   localparam logic [31:0] RecipN  = 32'((64'd1 << 31) / NUM_DISKS);
   localparam logic [31:0] RecipH  = 32'((64'd1 << 31) / Half);
   localparam logic [31:0] RecipN1 = 32'((64'd1 << 31) / (NUM_DISKS - 1));
   localparam logic [31:0] RecipOne = 32'h8000_0000;
   localparam logic [DskW-1:0] DivN  = DskW'(NUM_DISKS);
   localparam logic [DskW-1:0] DivH  = DskW'(Half);
   localparam logic [DskW-1:0] DivN1 = DskW'(NUM_DISKS - 1);
   localparam logic [LbW:0]    BlkLimit = (LbW+1)'(DISK_BLOCKS);

   // configuration
   logic                               present_ff;
   logic [rrcs_pkg::LevelW-1:0]        level_ff;
   logic [rrcs_pkg::CsrDataW-1:0]      ok_mask_ff;

   // request and mapping
   logic                       op_ff;
   logic [LbW-1:0]             lb_ff;
   logic [ProdW-1:0]           prod_ff;
   logic [LbW-1:0]             b_ff;
   logic [DskW-1:0]            d_ff;
   logic [DskW-1:0]            p_ff;

   // plan
   logic [rrcs_pkg::StatW-1:0] err_ff;
   logic [NUM_DISKS-1:0]       mask_ff;
   logic [rrcs_pkg::CmdW-1:0]  scan_cmd_ff;
   logic                       ret_ff;
   logic [IdxW-1:0]            idx_ff;

   // result register
   logic                       rsp_valid_ff;
   logic [rrcs_pkg::CmdW-1:0]  rsp_command_ff, rsp_command_in;
   logic [DskW-1:0]            rsp_disk_ff, rsp_disk_in;
   logic [rrcs_pkg::BlkW-1:0]  rsp_blk_ff, rsp_blk_in;
   logic [rrcs_pkg::StatW-1:0] rsp_status_ff, rsp_status_in;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         level_ff   <= '0;
         ok_mask_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            rrcs_pkg::REG_ARRAY_PRESENT: present_ff <= csr_wdata[0];
            rrcs_pkg::REG_RAID_LEVEL:    level_ff   <= csr_wdata[rrcs_pkg::LevelW-1:0];
            rrcs_pkg::REG_DISK_OK_MASK:  ok_mask_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // divide by the level's divisor, or by the disk count on the second pass
   logic [DskW-1:0]  div1, dsel;
   logic [31:0]      recip1, rsel;
   logic [LbW-1:0]   num;
   logic [ProdW-1:0] prod_in;
   logic [LbW-1:0]   q_est, q_fix;
   logic [RemW-1:0]  qd, rem_raw;
   logic [DskW-1:0]  r_fix;
   logic [DskW-1:0]  p_in;

   always_comb begin
      case (level_ff)
         rrcs_pkg::LVL_RAID0: begin
            div1   = DivN;
            recip1 = RecipN;
         end
         rrcs_pkg::LVL_RAID1: begin
            div1   = DskW'(1);
            recip1 = RecipOne;
         end
         rrcs_pkg::LVL_RAID01: begin
            div1   = DivH;
            recip1 = RecipH;
         end
         default: begin
            div1   = DivN1;
            recip1 = RecipN1;
         end
      endcase
      num     = cmd.pass2 ? b_ff : lb_ff;
      dsel    = cmd.pass2 ? DivN : div1;
      rsel    = cmd.pass2 ? RecipN : recip1;
      prod_in = ProdW'(num) * ProdW'(rsel);
      q_est   = prod_ff[LbW+30:31];
      qd      = RemW'(q_est) * RemW'(dsel);
      rem_raw = RemW'(num) - qd;
      if (rem_raw >= RemW'(dsel)) begin
         q_fix = q_est + LbW'(1);
         r_fix = DskW'(rem_raw - RemW'(dsel));
      end else begin
         q_fix = q_est;
         r_fix = DskW'(rem_raw);
      end
      // raid4 keeps parity on the last disk, raid5 rotates it downward
      if (level_ff == rrcs_pkg::LVL_RAID4) begin
         p_in = DivN;
      end else begin
         p_in = DivN - r_fix;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         lb_ff <= req_logical_block;
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.fix && !cmd.pass2) begin
         b_ff <= q_fix;
         d_ff <= r_fix + DskW'(1);
      end
      if (cmd.fix && cmd.pass2) begin
         p_ff <= p_in;
         // raid5 data disks skip over the parity disk
         if (level_ff == rrcs_pkg::LVL_RAID5 && d_ff >= p_in) begin
            d_ff <= d_ff + DskW'(1);
         end
      end
   end

   // command plan
   logic [NUM_DISKS-1:0]       ok_n, dbit, d2bit, pbit, lowest;
   logic                       d_ok, d2_ok, p_ok, range_bad;
   logic [rrcs_pkg::CmdW-1:0]  rw_cmd;
   logic [rrcs_pkg::StatW-1:0] plan_err_code;
   logic [NUM_DISKS-1:0]       plan_mask;
   logic [rrcs_pkg::CmdW-1:0]  plan_cmd;
   logic                       plan_ret, plan_rmw;

   always_comb begin
      ok_n      = ok_mask_ff[NUM_DISKS-1:0];
      dbit      = NUM_DISKS'(1) << (d_ff - DskW'(1));
      d2bit     = dbit << Half;
      pbit      = NUM_DISKS'(1) << (p_ff - DskW'(1));
      lowest    = ok_n & (~ok_n + NUM_DISKS'(1));
      d_ok      = |(ok_n & dbit);
      d2_ok     = |(ok_n & d2bit);
      p_ok      = |(ok_n & pbit);
      range_bad = ((LbW+1)'(b_ff) + (LbW+1)'(1)) >= BlkLimit;
      rw_cmd    = op_ff ? rrcs_pkg::CMD_WRITE : rrcs_pkg::CMD_READ;

      plan_err_code = rrcs_pkg::STAT_OK;
      plan_mask     = '0;
      plan_cmd      = rw_cmd;
      plan_ret      = 1'b0;
      plan_rmw      = 1'b0;

      if (!present_ff || level_ff > rrcs_pkg::LVL_RAID5) begin
         plan_err_code = rrcs_pkg::STAT_NO_ARRAY;
      end else if (range_bad) begin
         plan_err_code = rrcs_pkg::STAT_RANGE;
      end else begin
         case (level_ff)
            rrcs_pkg::LVL_RAID0: begin
               if (d_ok) begin
                  plan_mask = dbit;
               end else begin
                  plan_err_code = rrcs_pkg::STAT_DISK_DOWN;
               end
            end
            rrcs_pkg::LVL_RAID1: begin
               if (ok_n == '0) begin
                  plan_err_code = rrcs_pkg::STAT_DISK_DOWN;
               end else begin
                  plan_mask = op_ff ? ok_n : lowest;
               end
            end
            rrcs_pkg::LVL_RAID01: begin
               if (op_ff) begin
                  plan_mask = (dbit | d2bit) & ok_n;
                  if (!d_ok && !d2_ok) begin
                     plan_err_code = rrcs_pkg::STAT_DISK_DOWN;
                  end
               end else if (d_ok) begin
                  plan_mask = dbit;
               end else if (d2_ok) begin
                  plan_mask = d2bit;
               end else begin
                  plan_err_code = rrcs_pkg::STAT_DISK_DOWN;
               end
            end
            default: begin
               if (!op_ff) begin
                  if (d_ok) begin
                     plan_mask = dbit;
                  end else if ((ok_n | dbit) != {NUM_DISKS{1'b1}}) begin
                     plan_err_code = rrcs_pkg::STAT_DISK_DOWN;
                  end else begin
                     // rebuild from every other disk, then hand back the sum
                     plan_mask = ~dbit;
                     plan_cmd  = rrcs_pkg::CMD_RDXOR;
                     plan_ret  = 1'b1;
                  end
               end else if (!d_ok) begin
                  plan_err_code = rrcs_pkg::STAT_DISK_DOWN;
               end else if (!p_ok) begin
                  plan_mask = dbit;
               end else begin
                  plan_rmw = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.plan) begin
         err_ff      <= plan_err_code;
         mask_ff     <= plan_mask;
         scan_cmd_ff <= plan_cmd;
         ret_ff      <= plan_ret;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.plan) begin
         idx_ff <= '0;
      end else if (cmd.idx_step) begin
         idx_ff <= idx_ff + IdxW'(1);
      end
   end

   always_comb begin
      stat.plan_err  = (plan_err_code != rrcs_pkg::STAT_OK);
      stat.plan_rmw  = plan_rmw;
      stat.ret_after = ret_ff;
      stat.hit       = mask_ff[idx_ff];
      stat.more      = ((mask_ff >> idx_ff) >> 1) != '0;
   end

   // result word
   logic [rrcs_pkg::BlkW-1:0] pblk;

   always_comb begin
      pblk           = b_ff[rrcs_pkg::BlkW-1:0] + rrcs_pkg::BlkW'(1);
      rsp_command_in = rrcs_pkg::CMD_NONE;
      rsp_disk_in    = '0;
      rsp_blk_in     = '0;
      rsp_status_in  = rrcs_pkg::STAT_OK;
      case (cmd.emit_kind)
         rrcs_pkg::EM_ERR: begin
            rsp_status_in = err_ff;
         end
         rrcs_pkg::EM_SCAN: begin
            rsp_command_in = scan_cmd_ff;
            rsp_disk_in    = DskW'(idx_ff) + DskW'(1);
            rsp_blk_in     = pblk;
         end
         rrcs_pkg::EM_RET: begin
            rsp_command_in = rrcs_pkg::CMD_RET;
         end
         rrcs_pkg::EM_RD_DATA: begin
            rsp_command_in = rrcs_pkg::CMD_RDXOR;
            rsp_disk_in    = d_ff;
            rsp_blk_in     = pblk;
         end
         rrcs_pkg::EM_WR_DATA: begin
            rsp_command_in = rrcs_pkg::CMD_WRITE;
            rsp_disk_in    = d_ff;
            rsp_blk_in     = pblk;
         end
         rrcs_pkg::EM_RD_PAR: begin
            rsp_command_in = rrcs_pkg::CMD_RDXOR;
            rsp_disk_in    = p_ff;
            rsp_blk_in     = pblk;
         end
         rrcs_pkg::EM_HXOR: begin
            rsp_command_in = rrcs_pkg::CMD_HXOR;
         end
         rrcs_pkg::EM_WACC: begin
            rsp_command_in = rrcs_pkg::CMD_WACC;
            rsp_disk_in    = p_ff;
            rsp_blk_in     = pblk;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_valid) begin
         rsp_command_ff <= rsp_command_in;
         rsp_disk_ff    <= rsp_disk_in;
         rsp_blk_ff     <= rsp_blk_in;
         rsp_status_ff  <= rsp_status_in;
         rsp_last_ff    <= cmd.emit_last;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_command        = rsp_command_ff;
   assign rsp_disk_number    = rsp_disk_ff;
   assign rsp_physical_block = rsp_blk_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last_command   = rsp_last_ff;

endmodule

`default_nettype wire

// ----- hdl/raid_request_command_sequencer.sv -----
// raid_request_command_sequencer: top level, joins rrcs_ctrl and rrcs_dp
// depends on rrcs_pkg, rrcs_ctrl, rrcs_dp
//
// A request is taken when start is high and busy is low. Mapping runs two
// passes through one reciprocal multiplier, each with a remainder fix, then a
// planning step, after which the command words are issued, and each result
// word shows on the rsp_ ports, strobed by rsp_valid, in the cycle after it is
// issued. An error answer is a single word; a raid4/5 parity update issues a
// read-xor of the data disk, a write of it, a read-xor of the parity disk, a
// host xor and a write-accumulate to the parity disk. Every other request
// walks the disks one at a time from disk 1 up to the highest disk it uses, so
// a lone command on a high disk waits while the lower disks are passed and the
// words of a multi-disk request may have idle gaps; a degraded raid4/5 read
// ends with an extra word that returns the accumulator. busy falls in the cycle the final
// word (rsp_last_command high) is shown. Result words cannot be held off: the
// receiver must take every strobed word. Configuration registers are written
// whenever csr_we is high, so write them only while busy is low.
`default_nettype none

module raid_request_command_sequencer #(
   parameter int NUM_DISKS   = 4,
   parameter int DISK_BLOCKS = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic                               req_op,
   input  wire logic [rrcs_pkg::LbW-1:0]           req_logical_block,
   output logic                                    rsp_valid,
   output logic [rrcs_pkg::CmdW-1:0]               rsp_command,
   output logic [rrcs_pkg::DiskW-1:0]              rsp_disk_number,
   output logic [rrcs_pkg::BlkW-1:0]               rsp_physical_block,
   output logic [rrcs_pkg::StatW-1:0]              rsp_status,
   output logic                                    rsp_last_command,
   input  wire logic                               csr_we,
   input  wire logic [rrcs_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [rrcs_pkg::CsrDataW-1:0]      csr_wdata
);

   rrcs_pkg::ctl_cmd_type ctl_cmd;
   rrcs_pkg::dp_stat_type dp_stat;

   rrcs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (dp_stat),
      .cmd   (ctl_cmd)
   );

   rrcs_dp #(
      .NUM_DISKS   (NUM_DISKS),
      .DISK_BLOCKS (DISK_BLOCKS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_op             (req_op),
      .req_logical_block  (req_logical_block),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (ctl_cmd),
      .stat               (dp_stat),
      .rsp_valid          (rsp_valid),
      .rsp_command        (rsp_command),
      .rsp_disk_number    (rsp_disk_number),
      .rsp_physical_block (rsp_physical_block),
      .rsp_status         (rsp_status),
      .rsp_last_command   (rsp_last_command)
   );

endmodule

`default_nettype wire

// ----- hdl/rrcs_checker.sv -----
// rrcs_checker: port-level assertions for raid_request_command_sequencer
// bound to the top level below; uses rrcs_pkg
`default_nettype none

module rrcs_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         start,
   input wire logic                         busy,
   input wire logic                         rsp_valid,
   input wire logic [rrcs_pkg::CmdW-1:0]    rsp_command,
   input wire logic [rrcs_pkg::DiskW-1:0]   rsp_disk_number,
   input wire logic [rrcs_pkg::StatW-1:0]   rsp_status,
   input wire logic                         rsp_last_command
);

   // an accepted request keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but busy not raised");

   // an error answer is a single final word with no disk
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != rrcs_pkg::STAT_OK) |->
         (rsp_last_command && rsp_command == rrcs_pkg::CMD_NONE &&
          rsp_disk_number == '0))
      else $error("malformed error word");

   // returning the accumulator ends a request and names no disk
   a_ret_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_command == rrcs_pkg::CMD_RET) |->
         (rsp_last_command && rsp_disk_number == '0))
      else $error("accumulator return not final");

   // the next request needs mapping time before its first word
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_command) |=> !rsp_valid)
      else $error("word right after the final word");

endmodule

bind raid_request_command_sequencer rrcs_checker u_rrcs_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_command      (rsp_command),
   .rsp_disk_number  (rsp_disk_number),
   .rsp_status       (rsp_status),
   .rsp_last_command (rsp_last_command)
);

`default_nettype wire

// ----- dv/tb_raid_request_command_sequencer.sv -----
// tb_raid_request_command_sequencer: self-checking bench for the raid request sequencer
// drives requests and register writes, predicts every disk command word and checks
// it; depends on rrcs_pkg and raid_request_command_sequencer
`timescale 1ns / 1ps

module tb_raid_request_command_sequencer;

   localparam int NUM_DISKS     = 4;
   localparam int DISK_BLOCKS   = 4096;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RAND_SEGMENTS = 15;
   localparam int SEGMENT_REQS  = 8;
   localparam logic [rrcs_pkg::CsrIdxW-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [rrcs_pkg::CmdW-1:0]  command;
      logic [rrcs_pkg::DiskW-1:0] disk;
      logic [rrcs_pkg::BlkW-1:0]  blk;
      logic [rrcs_pkg::StatW-1:0] status;
      logic                       last;
   } disk_word_type;

   typedef struct packed {
      logic                     op;
      logic [rrcs_pkg::LbW-1:0] lb;
   } raid_req_type;

   logic                          clock;
   logic                          reset;
   logic                          start = 1'b0;
   logic                          busy;
   logic                          req_op = 1'b0;
   logic [rrcs_pkg::LbW-1:0]      req_logical_block = '0;
   logic                          rsp_valid;
   logic [rrcs_pkg::CmdW-1:0]     rsp_command;
   logic [rrcs_pkg::DiskW-1:0]    rsp_disk_number;
   logic [rrcs_pkg::BlkW-1:0]     rsp_physical_block;
   logic [rrcs_pkg::StatW-1:0]    rsp_status;
   logic                          rsp_last_command;
   logic                          csr_we;
   logic [rrcs_pkg::CsrIdxW-1:0]  csr_index;
   logic [rrcs_pkg::CsrDataW-1:0] csr_wdata;

   // shadow of the array registers
   logic                          cfg_present;
   logic [rrcs_pkg::LevelW-1:0]   cfg_level;
   logic [7:0]                    cfg_mask;

   raid_req_type  pending_reqs[$];
   disk_word_type expected_words[$];
   raid_req_type  next_req;
   disk_word_type got_word;
   disk_word_type exp_word;

   bit          req_taken = 1'b0;
   int unsigned gap_pct;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned requests_taken = 0;
   int unsigned words_seen = 0;
   int unsigned rebuild_reads = 0;
   int unsigned parity_updates = 0;
   int unsigned error_answers = 0;

   raid_request_command_sequencer #(
      .NUM_DISKS(NUM_DISKS),
      .DISK_BLOCKS(DISK_BLOCKS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_logical_block(req_logical_block),
      .rsp_valid(rsp_valid),
      .rsp_command(rsp_command),
      .rsp_disk_number(rsp_disk_number),
      .rsp_physical_block(rsp_physical_block),
      .rsp_status(rsp_status),
      .rsp_last_command(rsp_last_command),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit disk_up(input int unsigned d);
      if (d < 1 || d > NUM_DISKS) return 1'b0;
      return cfg_mask[d-1];
   endfunction

   function automatic disk_word_type make_word(input logic [rrcs_pkg::CmdW-1:0] cmd,
                                               input int unsigned disk,
                                               input int unsigned blk,
                                               input logic [rrcs_pkg::StatW-1:0] stat);
      disk_word_type w;
      w.command = cmd;
      w.disk    = disk[rrcs_pkg::DiskW-1:0];
      w.blk     = blk[rrcs_pkg::BlkW-1:0];
      w.status  = stat;
      w.last    = 1'b0;
      return w;
   endfunction

   // map one request to its disk command words and queue them
   task automatic plan_disk_commands(input logic op, input logic [rrcs_pkg::LbW-1:0] lb);
      disk_word_type              seq[$];
      disk_word_type              w;
      int unsigned                n, h, d, d2, b, p, blk;
      bit                         failed;
      bit                         other_down;
      logic [rrcs_pkg::StatW-1:0] fail_stat;
      logic [rrcs_pkg::CmdW-1:0]  host_cmd;
      n = NUM_DISKS;
      h = n / 2;
      d = 0;
      b = 0;
      p = n;
      failed = 1'b0;
      fail_stat = rrcs_pkg::STAT_OK;
      host_cmd = op ? rrcs_pkg::CMD_WRITE : rrcs_pkg::CMD_READ;
      if (!cfg_present || cfg_level > rrcs_pkg::LVL_RAID5) begin
         failed = 1'b1;
         fail_stat = rrcs_pkg::STAT_NO_ARRAY;
      end else begin
         case (cfg_level)
            rrcs_pkg::LVL_RAID0: begin
               d = lb % n + 1;
               b = lb / n;
            end
            rrcs_pkg::LVL_RAID1: begin
               d = 1;
               b = lb;
            end
            rrcs_pkg::LVL_RAID01: begin
               d = lb % h + 1;
               b = lb / h;
            end
            default: begin
               d = lb % (n - 1) + 1;
               b = lb / (n - 1);
            end
         endcase
         if (b + 1 >= DISK_BLOCKS) begin
            failed = 1'b1;
            fail_stat = rrcs_pkg::STAT_RANGE;
         end
      end
      blk = b + 1;
      if (!failed) begin
         case (cfg_level)
            rrcs_pkg::LVL_RAID0: begin
               if (disk_up(d)) seq.push_back(make_word(host_cmd, d, blk, rrcs_pkg::STAT_OK));
            end
            rrcs_pkg::LVL_RAID1: begin
               // reads stop at the lowest working disk, writes hit them all
               for (int unsigned i = 1; i <= n; i++)
                  if (disk_up(i) && !(op == 1'b0 && seq.size() != 0))
                     seq.push_back(make_word(host_cmd, i, blk, rrcs_pkg::STAT_OK));
            end
            rrcs_pkg::LVL_RAID01: begin
               d2 = d + h;
               if (op == 1'b0) begin
                  if (disk_up(d))
                     seq.push_back(make_word(rrcs_pkg::CMD_READ, d, blk, rrcs_pkg::STAT_OK));
                  else if (disk_up(d2))
                     seq.push_back(make_word(rrcs_pkg::CMD_READ, d2, blk, rrcs_pkg::STAT_OK));
               end else begin
                  if (disk_up(d))
                     seq.push_back(make_word(rrcs_pkg::CMD_WRITE, d, blk, rrcs_pkg::STAT_OK));
                  if (disk_up(d2))
                     seq.push_back(make_word(rrcs_pkg::CMD_WRITE, d2, blk, rrcs_pkg::STAT_OK));
               end
            end
            default: begin
               if (cfg_level == rrcs_pkg::LVL_RAID5) begin
                  p = n - b % n;
                  if (d >= p) d++;
               end
               if (op == 1'b0) begin
                  if (disk_up(d)) begin
                     seq.push_back(make_word(rrcs_pkg::CMD_READ, d, blk, rrcs_pkg::STAT_OK));
                  end else begin
                     other_down = 1'b0;
                     for (int unsigned i = 1; i <= n; i++)
                        if (i != d && !disk_up(i)) other_down = 1'b1;
                     if (!other_down) begin
                        // rebuild from the surviving disks
                        for (int unsigned i = 1; i <= n; i++)
                           if (i != d)
                              seq.push_back(make_word(rrcs_pkg::CMD_RDXOR, i, blk,
                                                      rrcs_pkg::STAT_OK));
                        seq.push_back(make_word(rrcs_pkg::CMD_RET, 0, 0, rrcs_pkg::STAT_OK));
                        rebuild_reads++;
                     end
                  end
               end else if (disk_up(d)) begin
                  if (!disk_up(p)) begin
                     seq.push_back(make_word(rrcs_pkg::CMD_WRITE, d, blk, rrcs_pkg::STAT_OK));
                  end else begin
                     seq.push_back(make_word(rrcs_pkg::CMD_RDXOR, d, blk, rrcs_pkg::STAT_OK));
                     seq.push_back(make_word(rrcs_pkg::CMD_WRITE, d, blk, rrcs_pkg::STAT_OK));
                     seq.push_back(make_word(rrcs_pkg::CMD_RDXOR, p, blk, rrcs_pkg::STAT_OK));
                     seq.push_back(make_word(rrcs_pkg::CMD_HXOR, 0, 0, rrcs_pkg::STAT_OK));
                     seq.push_back(make_word(rrcs_pkg::CMD_WACC, p, blk, rrcs_pkg::STAT_OK));
                     parity_updates++;
                  end
               end
            end
         endcase
         if (seq.size() == 0) begin
            failed = 1'b1;
            fail_stat = rrcs_pkg::STAT_DISK_DOWN;
         end
      end
      if (failed) begin
         seq.delete();
         seq.push_back(make_word(rrcs_pkg::CMD_NONE, 0, 0, fail_stat));
         error_answers++;
      end
      w = seq.pop_back();
      w.last = 1'b1;
      seq.push_back(w);
      foreach (seq[k]) expected_words.push_back(seq[k]);
   endtask

   task automatic note_mismatch(input string what, input disk_word_type exp,
                                input disk_word_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t: %s: exp cmd %0d disk %0d blk %0d st %0d last %0d,",
                   " got cmd %0d disk %0d blk %0d st %0d last %0d"},
                  $time, what, exp.command, exp.disk, exp.blk, exp.status, exp.last,
                  got.command, got.disk, got.blk, got.status, got.last);
   endtask

   // request driver: fields change on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
            next_req = pending_reqs.pop_front();
            start <= 1'b1;
            req_op <= next_req.op;
            req_logical_block <= next_req.lb;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: takes requests and result words at the rising edge
   always @(posedge clock) begin
      cycle_count++;
      req_taken = 1'b0;
      if (!reset) begin
         if (start && !busy) begin
            req_taken = 1'b1;
            requests_taken++;
            plan_disk_commands(req_op, req_logical_block);
         end
         if (rsp_valid) begin
            words_seen++;
            got_word = '{rsp_command, rsp_disk_number, rsp_physical_block, rsp_status,
                         rsp_last_command};
            if (expected_words.size() == 0) begin
               note_mismatch("unexpected word", '0, got_word);
            end else begin
               exp_word = expected_words.pop_front();
               if (got_word.command !== exp_word.command || got_word.disk !== exp_word.disk ||
                   got_word.blk !== exp_word.blk || got_word.status !== exp_word.status ||
                   got_word.last !== exp_word.last)
                  note_mismatch("word mismatch", exp_word, got_word);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               expected_words.size());
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic add_req(input logic op, input logic [rrcs_pkg::LbW-1:0] lb);
      raid_req_type r;
      r.op = op;
      r.lb = lb;
      pending_reqs.push_back(r);
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || start || expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // waits for the array to go quiet, then writes all registers
   task automatic program_array(input logic present, input logic [rrcs_pkg::LevelW-1:0] lvl,
                                input logic [7:0] mask);
      logic [rrcs_pkg::CsrDataW-1:0] wd;
      drain();
      @(negedge clock);
      wd = rrcs_pkg::CsrDataW'($urandom);
      wd[0] = present;
      csr_we <= 1'b1;
      csr_index <= rrcs_pkg::REG_ARRAY_PRESENT;
      csr_wdata <= wd;
      @(negedge clock);
      wd = rrcs_pkg::CsrDataW'($urandom);
      wd[rrcs_pkg::LevelW-1:0] = lvl;
      csr_index <= rrcs_pkg::REG_RAID_LEVEL;
      csr_wdata <= wd;
      @(negedge clock);
      csr_index <= rrcs_pkg::REG_DISK_OK_MASK;
      csr_wdata <= mask;
      @(negedge clock);
      // no register behind this index
      csr_index <= REG_UNUSED;
      csr_wdata <= rrcs_pkg::CsrDataW'($urandom);
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_present = present;
      cfg_level = lvl;
      cfg_mask = mask;
   endtask

   function automatic logic [rrcs_pkg::LbW-1:0] pick_block(
      input logic [rrcs_pkg::LevelW-1:0] lvl);
      int unsigned span;
      int unsigned r;
      int unsigned v;
      case (lvl)
         rrcs_pkg::LVL_RAID0:  span = NUM_DISKS * (DISK_BLOCKS - 1);
         rrcs_pkg::LVL_RAID1:  span = DISK_BLOCKS - 1;
         rrcs_pkg::LVL_RAID01: span = (NUM_DISKS / 2) * (DISK_BLOCKS - 1);
         rrcs_pkg::LVL_RAID4,
         rrcs_pkg::LVL_RAID5:  span = (NUM_DISKS - 1) * (DISK_BLOCKS - 1);
         default:              span = 65536;
      endcase
      if (span > 65536) span = 65536;
      r = $urandom_range(99);
      if (r < 75) v = $urandom_range(span - 1, 0);
      else if (r < 85) v = span - 2 + $urandom_range(3);
      else v = $urandom;
      return v[rrcs_pkg::LbW-1:0];
   endfunction

   initial begin
      logic [rrcs_pkg::LevelW-1:0] lvl;
      logic [7:0]                  mask;
      logic                        present;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      cfg_present = 1'b0;
      cfg_level = rrcs_pkg::LVL_RAID0;
      cfg_mask = 8'h00;
      gap_pct = 15;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: no array after reset, then an undefined level
      add_req(1'b0, 16'h0000);
      program_array(1'b1, 3'd7, 8'hFF);
      add_req(1'b1, 16'hFFFF);
      // raid0 across the range boundary
      program_array(1'b1, rrcs_pkg::LVL_RAID0, 8'hFF);
      add_req(1'b0, 16'd0);
      add_req(1'b1, 16'd16379);
      add_req(1'b0, 16'd16380);
      add_req(1'b1, 16'hFFFF);
      // raid1 with the low disks down, then with no real disk up
      program_array(1'b1, rrcs_pkg::LVL_RAID1, 8'h0C);
      add_req(1'b0, 16'd5);
      add_req(1'b1, 16'd4094);
      add_req(1'b0, 16'd4095);
      program_array(1'b1, rrcs_pkg::LVL_RAID1, 8'hF0);
      add_req(1'b1, 16'd1);
      // raid0+1 falling back to the second copy
      program_array(1'b1, rrcs_pkg::LVL_RAID01, 8'h06);
      add_req(1'b0, 16'd0);
      add_req(1'b1, 16'd0);
      add_req(1'b1, 16'd1);
      add_req(1'b0, 16'd8189);
      // raid4 degraded read, dead data disk on write, parity update
      program_array(1'b1, rrcs_pkg::LVL_RAID4, 8'h0E);
      add_req(1'b0, 16'd0);
      add_req(1'b1, 16'd0);
      add_req(1'b1, 16'd1);
      // raid4 with the parity disk down
      program_array(1'b1, rrcs_pkg::LVL_RAID4, 8'h07);
      add_req(1'b1, 16'd2);
      add_req(1'b0, 16'd12284);
      // raid5 rotating parity with one disk down
      program_array(1'b1, rrcs_pkg::LVL_RAID5, 8'h0B);
      add_req(1'b0, 16'd2);
      add_req(1'b1, 16'd3);
      add_req(1'b1, 16'd0);
      add_req(1'b0, 16'd12285);
      // raid5 degraded read with a second disk down
      program_array(1'b1, rrcs_pkg::LVL_RAID5, 8'h09);
      add_req(1'b0, 16'd2);

      // random segments: sender gaps 15%, then 79%, then none
      for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
         present = ($urandom_range(9) != 0);
         lvl = ($urandom_range(7) == 0) ? 3'($urandom_range(7, 5)) : 3'(seg % 5);
         case ($urandom_range(3))
            0: mask = {4'($urandom), 4'hF};
            1: mask = {4'($urandom), 4'hF & ~(4'b1 << $urandom_range(NUM_DISKS - 1))};
            2: mask = 8'($urandom);
            default: mask = {4'($urandom), 4'($urandom) & 4'($urandom)};
         endcase
         program_array(present, lvl, mask);
         gap_pct = (seg < 5) ? 15 : (seg < 10) ? 79 : 0;
         for (int k = 0; k < SEGMENT_REQS; k++)
            add_req(1'($urandom_range(1)), pick_block(lvl));
      end
      drain();

      $display("ran %0d requests over raid0/1/0+1/4/5 and undefined levels, %0d command words",
               requests_taken, words_seen);
      $display("including %0d rebuild reads, %0d parity updates, %0d error answers",
               rebuild_reads, parity_updates, error_answers);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
